@@ design/i2p_pkg.sv @@
// Package for the infix-to-postfix converter: operator codes, ASCII constants
// and the code/character mapping helpers.
// No dependencies.
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  typedef logic [2:0] op_code_t;

  localparam op_code_t OP_ADD  = 3'd0;
  localparam op_code_t OP_SUB  = 3'd1;
  localparam op_code_t OP_MUL  = 3'd2;
  localparam op_code_t OP_DIV  = 3'd3;
  localparam op_code_t OP_LPAR = 3'd4;

  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;

  // Stack code back to its character; only arithmetic codes are ever emitted.
  function automatic logic [7:0] op_ascii(op_code_t c);
    logic [7:0] r;
    case (c)
      OP_ADD:  r = CH_ADD;
      OP_SUB:  r = CH_SUB;
      OP_MUL:  r = CH_MUL;
      OP_DIV:  r = CH_DIV;
      OP_LPAR: r = CH_LPAR;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Character to stack code for the four arithmetic operators.
  function automatic op_code_t op_of(logic [7:0] ch);
    op_code_t r;
    case (ch)
      CH_ADD:  r = OP_ADD;
      CH_SUB:  r = OP_SUB;
      CH_MUL:  r = OP_MUL;
      default: r = OP_DIV;
    endcase
    return r;
  endfunction

  function automatic logic is_arith(logic [7:0] ch);
    return (ch == CH_ADD) || (ch == CH_SUB) || (ch == CH_MUL) || (ch == CH_DIV);
  endfunction

endpackage

@@ design/infix_to_postfix_converter.sv @@
// Infix-to-postfix converter (shunting-yard), operator stack in a synchronous RAM.
// Depends on i2p_pkg. An operand or '(' is accepted in S_IDLE and released in
//   S_END; an operator or ')' passes through S_LOOP in between, popping each
//   operator it emits, and a last character also empties the stack in S_LOOP.
//   One pop per cycle, bound by the registered RAM read, unless the output stalls.
// Reset (rst, sync, active high) empties the stack, clears overflow and output.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_char
  input  logic        s_tlast,   // in_last
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [8] overflow, [15:9] zero
  output logic        m_tuser,   // has_char
  output logic        m_tlast    // out_end
);
  import i2p_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transfer
  localparam logic [1:0] S_LOOP = 2'd1;  // popping, one entry per cycle unless the output stalls
  localparam logic [1:0] S_END  = 2'd2;  // release held result / end marker

  // what the pop loop is working for
  localparam logic [1:0] M_OPER  = 2'd0;  // incoming operator
  localparam logic [1:0] M_RPAR  = 2'd1;  // closing paren
  localparam logic [1:0] M_FLUSH = 2'd2;  // end of expression

  logic [1:0]       state, state_next;
  logic [1:0]       mode, mode_next;
  logic [7:0]       ch_q;
  logic             last_q;
  logic [CNT_W-1:0] cnt, cnt_next, cnt_dec;
  logic             ovf;

  // The newest emitted char is held back one step so out_end can be
  // stamped on it once the expression is known to be finished.
  logic             hold_valid;
  logic [7:0]       hold_char;

  logic [7:0]       out_char;
  logic             out_has, out_end, out_ovf;

  // stack RAM
  op_code_t         mem [STACK_DEPTH];
  op_code_t         rd_raw, fwd_data, top;
  logic             fwd_valid;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic             push_req, emit_req, fin, fin_need;
  op_code_t         push_code;
  op_code_t         in_code;
  logic [7:0]       emit_char;
  logic             out_free, emit_ok, room;

  assign out_free = !m_tvalid || m_tready;
  assign emit_ok  = !hold_valid || out_free;
  assign room     = cnt < CNT_FULL;
  assign top      = fwd_valid ? fwd_data : rd_raw;
  assign fin_need = last_q || hold_valid;
  assign in_code  = op_of(ch_q);

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cnt_next   = cnt;
    push_req   = 1'b0;
    push_code  = OP_ADD;
    emit_req   = 1'b0;
    emit_char  = ch_q;
    fin        = 1'b0;
    s_tready   = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata == CH_LPAR) begin
            push_req   = 1'b1;
            push_code  = OP_LPAR;
            mode_next  = M_FLUSH;
            state_next = s_tlast ? S_LOOP : S_END;
          end else if (s_tdata == CH_RPAR) begin
            mode_next  = M_RPAR;
            state_next = S_LOOP;
          end else if (is_arith(s_tdata)) begin
            mode_next  = M_OPER;
            state_next = S_LOOP;
          end else begin
            // operand: straight out (hold is empty between items)
            emit_req   = 1'b1;
            emit_char  = s_tdata;
            mode_next  = M_FLUSH;
            state_next = s_tlast ? S_LOOP : S_END;
          end
        end
      end

      S_LOOP: begin
        if (cnt == '0) begin
          case (mode)
            M_OPER: begin
              push_req   = 1'b1;
              push_code  = in_code;
              mode_next  = M_FLUSH;
              state_next = last_q ? S_LOOP : S_END;
            end
            M_RPAR: begin
              mode_next  = M_FLUSH;
              state_next = last_q ? S_LOOP : S_END;
            end
            default: state_next = S_END;
          endcase
        end else begin
          case (mode)
            M_OPER: begin
              // stop at '(' or a lower-precedence operator, then push
              if (top == OP_LPAR || top[1] < in_code[1]) begin
                push_req   = 1'b1;
                push_code  = in_code;
                mode_next  = M_FLUSH;
                state_next = last_q ? S_LOOP : S_END;
              end else if (emit_ok) begin
                cnt_next  = cnt - CNT_W'(1);
                emit_req  = 1'b1;
                emit_char = op_ascii(top);
              end
            end
            M_RPAR: begin
              if (top == OP_LPAR) begin
                cnt_next   = cnt - CNT_W'(1);
                mode_next  = M_FLUSH;
                state_next = last_q ? S_LOOP : S_END;
              end else if (emit_ok) begin
                cnt_next  = cnt - CNT_W'(1);
                emit_req  = 1'b1;
                emit_char = op_ascii(top);
              end
            end
            default: begin
              // flush: unmatched '(' just vanish
              if (top == OP_LPAR) begin
                cnt_next = cnt - CNT_W'(1);
              end else if (emit_ok) begin
                cnt_next  = cnt - CNT_W'(1);
                emit_req  = 1'b1;
                emit_char = op_ascii(top);
              end
            end
          endcase
        end
      end

      S_END: begin
        if (!fin_need || out_free) begin
          fin        = fin_need;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (push_req && room) begin
      cnt_next = cnt + CNT_W'(1);
    end
  end

  // read the entry that will be on top next cycle
  assign cnt_dec = cnt_next - CNT_W'(1);
  assign rd_addr = cnt_dec[ADDR_W-1:0];
  assign wr_addr = cnt[ADDR_W-1:0];
  assign wr_en   = push_req && room;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_code;
    end
    rd_raw    <= mem[rd_addr];
    // push and read of the same entry in one cycle: forward the new code
    fwd_valid <= wr_en && (wr_addr == rd_addr);
    fwd_data  <= push_code;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_FLUSH;
      cnt        <= '0;
      ovf        <= 1'b0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      cnt   <= cnt_next;
      if (push_req && !room) begin
        ovf <= 1'b1;
      end
      if (emit_req) begin
        hold_valid <= 1'b1;
      end else if (fin) begin
        hold_valid <= 1'b0;
      end
      if ((emit_req && hold_valid) || fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch_q   <= s_tdata;
      last_q <= s_tlast;
    end
    if (emit_req) begin
      hold_char <= emit_char;
    end
    if ((emit_req && hold_valid) || fin) begin
      // bare end marker when nothing was emitted
      out_char <= hold_valid ? hold_char : 8'h00;
      out_has  <= hold_valid;
      out_end  <= fin && last_q;
      out_ovf  <= ovf;
    end
  end

  assign m_tdata = {7'b0, out_ovf, out_char};
  assign m_tuser = out_has;
  assign m_tlast = out_end;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("stack count beyond depth");

  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("held result left over between items");

  a_stack_empty_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && last_q) |-> (cnt == '0))
    else $error("stack not empty after final flush");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  a_fwd_on_push_flush: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state_next == S_LOOP) |=> fwd_valid)
    else $error("push before flush not forwarded");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for infix_to_postfix_converter: streams infix
// expressions in and checks every postfix transfer against a shunting-yard
// predictor held here. Depends on i2p_pkg and the converter RTL.
module tb;
  import i2p_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 240;
  localparam int STUCK_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 60;

  // operator characters by stack code, and all six special characters
  localparam logic [3:0][7:0] OP_SYM  = {CH_DIV, CH_MUL, CH_SUB, CH_ADD};
  localparam logic [5:0][7:0] SPECIAL = {CH_RPAR, CH_LPAR, CH_DIV, CH_MUL, CH_SUB, CH_ADD};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } infix_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       fin;
    logic       ovf;
  } postfix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  infix_char_t infix_q[$];     // characters waiting to be driven
  postfix_t    postfix_q[$];   // predicted postfix transfers, oldest first

  // predictor state
  op_code_t op_stk [DEPTH];
  int       stk_n    = 0;
  bit       ovf_seen = 1'b0;

  int errors       = 0;
  int exprs_queued = 0;
  int chars_queued = 0;
  int chars_sent   = 0;
  int results_seen = 0;
  int peak_results = 0;
  int stuck_cycles = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] in_char
    .s_tlast  (s_tlast),    // in_last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [7:0] out_char, [8] overflow, [15:9] zero
    .m_tuser  (m_tuser),    // has_char
    .m_tlast  (m_tlast)     // out_end
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shunting-yard predictor
  // ---------------------------------------------------------------------------
  function automatic postfix_t emitted(logic [7:0] c);
    postfix_t r;
    r.ch  = c;
    r.has = 1'b1;
    r.fin = 1'b0;
    r.ovf = 1'b0;
    return r;
  endfunction

  // a push onto a full stack is lost and trips the sticky overflow flag
  function automatic void stack_push(op_code_t code);
    if (stk_n < DEPTH) begin
      op_stk[IDX_W'(stk_n)] = code;
      stk_n++;
    end else begin
      ovf_seen = 1'b1;
    end
  endfunction

  function automatic void convert_char(logic [7:0] ch, logic last);
    postfix_t res[$];
    postfix_t tmp;
    op_code_t code;
    op_code_t top;
    if (ch == CH_LPAR) begin
      stack_push(OP_LPAR);
    end else if (ch == CH_RPAR) begin
      // pop down to the matching '(' or, if unmatched, to an empty stack
      while (stk_n > 0) begin
        top = op_stk[IDX_W'(stk_n - 1)];
        stk_n--;
        if (top == OP_LPAR) break;
        res.push_back(emitted(OP_SYM[top[1:0]]));
      end
    end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV) begin
      case (ch)
        CH_ADD:  code = OP_ADD;
        CH_SUB:  code = OP_SUB;
        CH_MUL:  code = OP_MUL;
        default: code = OP_DIV;
      endcase
      // left-associative: pop everything of equal or higher precedence
      while (stk_n > 0) begin
        top = op_stk[IDX_W'(stk_n - 1)];
        if (top == OP_LPAR || top[1] < code[1]) break;
        stk_n--;
        res.push_back(emitted(OP_SYM[top[1:0]]));
      end
      stack_push(code);
    end else begin
      res.push_back(emitted(ch));
    end

    if (last) begin
      // final flush; stray '(' vanish without output
      while (stk_n > 0) begin
        top = op_stk[IDX_W'(stk_n - 1)];
        stk_n--;
        if (top != OP_LPAR) res.push_back(emitted(OP_SYM[top[1:0]]));
      end
      if (res.size() == 0) begin
        tmp = emitted(8'h00);
        tmp.has = 1'b0;
        res.push_back(tmp);
      end
      tmp = res.pop_back();
      tmp.fin = 1'b1;
      res.push_back(tmp);
    end

    if (res.size() > peak_results) peak_results = res.size();
    // every transfer of a step carries the flag as it stands after the step
    foreach (res[i]) begin
      tmp = res[i];
      tmp.ovf = ovf_seen;
      postfix_q.push_back(tmp);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic add_char(logic [7:0] ch, logic last);
    infix_char_t it;
    it.ch   = ch;
    it.last = last;
    infix_q.push_back(it);
    chars_queued++;
    if (last) exprs_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
           c == CH_LPAR || c == CH_RPAR);
    return c;
  endfunction

  function automatic logic [7:0] rand_operator();
    return OP_SYM[2'($urandom_range(0, 3))];
  endfunction

  // Well-formed expression with random operands, operators and nesting.
  // A broken one may stop on an operator or '(' and may carry stray ')'.
  task automatic gen_expr(bit broken);
    int         len;
    int         depth;
    bit         need_opnd;
    logic [7:0] txt[$];
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 12);
    depth = 0;
    need_opnd = 1'b1;
    while (txt.size() < len) begin
      if (need_opnd) begin
        if (depth < 6 && $urandom_range(0, 3) == 0) begin
          txt.push_back(CH_LPAR);
          depth++;
        end else begin
          txt.push_back(rand_operand());
          need_opnd = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        txt.push_back(CH_RPAR);
        depth--;
      end else begin
        txt.push_back(rand_operator());
        need_opnd = 1'b1;
      end
    end
    if (!broken) begin
      if (need_opnd) txt.push_back(rand_operand());
      while (depth > 0) begin
        txt.push_back(CH_RPAR);
        depth--;
      end
    end else if ($urandom_range(0, 1) == 0) begin
      txt.insert($urandom_range(0, txt.size()), CH_RPAR);
    end
    foreach (txt[i]) add_char(txt[i], i == txt.size() - 1);
  endtask

  // Noise: any byte, heavy on the special characters.
  task automatic gen_noise(int len, int lpar_weight);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < lpar_weight)
        add_char(CH_LPAR, i == len - 1);
      else if (r < lpar_weight + 30)
        add_char(SPECIAL[3'($urandom_range(0, 5))], i == len - 1);
      else
        add_char(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int r;
    int target;
    // directed: byte extremes, precedence and associativity, parentheses,
    // unmatched ')' on empty and non-empty stack, unmatched '(', bare end
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    add_text("a+b*c-d/e");
    add_text("(a+b)*c");
    add_text(")");
    add_text("a-b)");
    add_text("((a");
    add_text("(");

    // random: overflow stays clear here, nesting is kept shallow
    target = chars_queued + RANDOM_ITEMS;
    while (chars_queued < target) begin
      r = $urandom_range(0, 19);
      if (r < 15)      gen_expr(1'b0);
      else if (r < 18) gen_expr(1'b1);
      else             gen_noise($urandom_range(1, 10), 10);
    end

    // full stack: "(+" pairs fill all entries, extra pushes are lost
    for (int i = 0; i < DEPTH / 2 + 2; i++) begin
      add_char(CH_LPAR, 1'b0);
      add_char(CH_ADD, 1'b0);
    end
    add_char(rand_operand(), 1'b1);
    gen_noise(DEPTH + 12, 50);
    gen_noise(DEPTH + 12, 50);
    // flag must stay set across later expressions
    for (int i = 0; i < 6; i++) gen_expr(1'b0);
  end

  // ---------------------------------------------------------------------------
  // Driver: one character at a time, random gap before each
  // ---------------------------------------------------------------------------
  infix_char_t cur_char;
  bit          drv_busy  = 1'b0;
  bit          drv_burst = 1'b0;
  int          drv_gap   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      drv_busy = 1'b0;
      drv_gap  = $urandom_range(0, 10);
    end else begin
      if (s_tvalid && s_tready) begin
        convert_char(cur_char.ch, cur_char.last);
        chars_sent++;
        drv_busy = 1'b0;
        if ($urandom_range(0, 29) == 0) drv_burst = !drv_burst;
        drv_gap = drv_burst ? 0 : $urandom_range(0, 10);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (infix_q.size() > 0) begin
          cur_char = infix_q.pop_front();
          drv_busy = 1'b1;
          s_tdata <= cur_char.ch;
          s_tlast <= cur_char.last;
        end
      end
      s_tvalid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, in-order compare against the predictor
  // ---------------------------------------------------------------------------
  bit       mon_burst = 1'b0;
  int       mon_stall = 0;
  postfix_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      mon_stall = $urandom_range(0, 10);
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (postfix_q.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display("%0t: unexpected transfer, expected none, got tdata=%h tuser=%b tlast=%b",
                     $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = postfix_q.pop_front();
          if (m_tdata !== {7'd0, want.ovf, want.ch} || m_tuser !== want.has ||
              m_tlast !== want.fin) begin
            errors++;
            if (errors <= 20)
              $display({"%0t: mismatch, expected char=%h has=%b end=%b ovf=%b, ",
                        "got tdata=%h tuser=%b tlast=%b"},
                       $time, want.ch, want.has, want.fin, want.ovf,
                       m_tdata, m_tuser, m_tlast);
          end
        end
        if ($urandom_range(0, 29) == 0) mon_burst = !mon_burst;
        mon_stall = mon_burst ? 0 : $urandom_range(0, 10);
      end
      if (mon_stall > 0) begin
        mon_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles since the last transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Reset, completion and verdict
  // ---------------------------------------------------------------------------
  initial begin
    bit timed_out;
    timed_out = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // sample on the falling edge, clear of the clocked updates
    @(negedge clk);
    while (infix_q.size() > 0 || drv_busy || postfix_q.size() > 0) begin
      @(negedge clk);
      if (stuck_cycles >= STUCK_LIMIT) begin
        timed_out = 1'b1;
        break;
      end
    end
    if (timed_out) begin
      $display("%0t: no transfer for %0d cycles, %0d transfers still expected",
               $time, STUCK_LIMIT, postfix_q.size());
      $display("infix_to_postfix_converter test failed");
    end else begin
      // anything arriving now is a stray transfer and is flagged by the monitor
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (postfix_q.size() > 0) begin
        errors++;
        $display("%0t: %0d predicted transfers never arrived", $time, postfix_q.size());
      end
      $display("Covered %0d expressions, %0d characters in, %0d postfix transfers checked.",
               exprs_queued, chars_sent, results_seen);
      $display("Largest burst from one character: %0d; stack overflow flag reached: %0d.",
               peak_results, ovf_seen);
      if (errors == 0)
        $display("infix_to_postfix_converter test passed");
      else
        $display("infix_to_postfix_converter test failed");
    end
    $finish;
  end

endmodule
